// ----- sv/tslg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslg_pkg: shared types and constants for the two-species life block
// State codes, request and cell codes, register indexes and the cell rule.
// ----------------------------------------------------------------------------
package tslg_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP,
        ST_GRD,
        ST_GWAIT,
        ST_GEVAL,
        ST_COPY,
        ST_COPYW
    } t_state;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_GEN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_BLUE  = 2'd1;
    localparam logic [1:0] CELL_RED   = 2'd2;
    localparam logic [1:0] CELL_BAD   = 2'd3;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_TOPO = 2'd2;

    localparam logic TOPO_TORUS = 1'b0;
    localparam logic TOPO_KLEIN = 1'b1;

    localparam logic [3:0] BIRTH_COUNT      = 4'd3;
    localparam logic [3:0] HIGH_BIRTH_COUNT = 4'd6;
    localparam logic [3:0] STAY_COUNT       = 4'd2;

    function automatic logic [1:0] cell_rule(logic [1:0] self, logic [3:0] blue,
                                             logic [3:0] red);
        logic [3:0] total;
        logic [1:0] res;
        total = blue + red;
        res   = CELL_EMPTY;
        if (self == CELL_EMPTY) begin
            if (total == BIRTH_COUNT) begin
                res = (blue > red) ? CELL_BLUE : CELL_RED;
            end else if (total == HIGH_BIRTH_COUNT && red > blue) begin
                res = CELL_RED;
            end
        end else if (total == STAY_COUNT || total == BIRTH_COUNT) begin
            res = self;
        end
        return res;
    endfunction

endpackage

// ----- sv/tslg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslg_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tslg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/two_species_life_generation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_species_life_generation: two-species life grid with write, read, step
// Holds the grid in memory and advances it one generation on request.
// ----------------------------------------------------------------------------
//  channel   handshake              word
//  request   start / busy           i_req_type i_row i_col i_cell_in
//  result    o_done (one cycle)     o_cell_out o_is_read
//  config    i_cfg_we               i_cfg_idx i_cfg_data
//
//  write and unused codes: result the cycle after accept, busy stays low
//  read: busy for one cycle in ST_RESP, result registered from there
//  generation: paced by the single read port of the grid memory
//    (3 reads per cell, 9 at row start)
//  reset: clearing pass over all MAX_ROWS * 2**clog2(MAX_COLS) words, busy high
//  the receiver cannot stall; each result is a one-cycle strobe
module two_species_life_generation
    import tslg_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_row,
    input  logic [5:0] i_col,
    input  logic [1:0] i_cell_in,
    output logic       o_done,
    output logic [1:0] o_cell_out,
    output logic       o_is_read,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    localparam int RI    = $clog2(MAX_ROWS);
    localparam int CI    = $clog2(MAX_COLS);
    localparam int RS    = $clog2(MAX_ROWS + 1);
    localparam int CS    = $clog2(MAX_COLS + 1);
    localparam int CP    = $clog2(MAX_COLS + 2);
    localparam int AW    = RI + CI;
    localparam int DEPTH = MAX_ROWS * (2 ** CI);

    function automatic logic [RS-1:0] clamp_rows(logic [6:0] v);
        if (v < 7'd4) return RS'(4);
        if (32'(v) > MAX_ROWS) return RS'(MAX_ROWS);
        return RS'(v);
    endfunction

    function automatic logic [CS-1:0] clamp_cols(logic [6:0] v);
        if (v < 7'd4) return CS'(4);
        if (32'(v) > MAX_COLS) return CS'(MAX_COLS);
        return CS'(v);
    endfunction

    t_state          r_state, n_state;
    logic [RS-1:0]   r_rows;
    logic [CS-1:0]   r_cols;
    logic            r_topo;
    logic [AW-1:0]   r_clr;
    logic [RI-1:0]   r_row;
    logic [CI-1:0]   r_col;
    logic [1:0]      r_i, r_j;
    logic            r_ld_vld;
    logic [1:0]      r_ld_i, r_ld_j;
    logic [1:0]      r_win [3][3];
    logic            r_cp_vld;
    logic [AW-1:0]   r_cp_addr;
    logic            r_req_in;
    logic            r_done;
    logic [1:0]      r_cell_out;
    logic            r_is_read;

    logic            accept;
    logic            req_inside;
    logic [AW-1:0]   req_addr;
    logic            last_row, last_col, last_rd, clr_last;
    logic            nb_wrap;
    logic [RI-1:0]   nb_row;
    logic [CP-1:0]   nb_cp;
    logic [CP-1:0]   nb_cpm;
    logic [CI-1:0]   nb_col;
    logic [3:0]      cnt_blue, cnt_red;
    logic [1:0]      new_cell;

    logic            cell_we;
    logic [AW-1:0]   cell_waddr;
    logic [1:0]      cell_wdata;
    logic [AW-1:0]   cell_raddr;
    logic [1:0]      cell_rdata;
    logic            next_we;
    logic [1:0]      next_rdata;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign req_inside = (32'(i_row) < 32'(r_rows)) && (32'(i_col) < 32'(r_cols));
    assign req_addr   = {RI'(i_row), CI'(i_col)};
    assign last_row   = (32'(r_row) == 32'(r_rows) - 1);
    assign last_col   = (32'(r_col) == 32'(r_cols) - 1);
    assign last_rd    = (r_i == 2'd2) && (r_j == 2'd2);
    assign clr_last   = (r_clr == AW'(DEPTH - 1));

    // neighbour address unit
    always_comb begin
        case (r_i)
            2'd0: begin
                nb_wrap = (r_row == '0);
                nb_row  = nb_wrap ? RI'(r_rows - 1'b1) : r_row - 1'b1;
            end
            2'd2: begin
                nb_wrap = last_row;
                nb_row  = nb_wrap ? '0 : r_row + 1'b1;
            end
            default: begin
                nb_wrap = 1'b0;
                nb_row  = r_row;
            end
        endcase
        nb_cp = CP'(r_col) + CP'(r_j);
        if (nb_wrap && r_topo == TOPO_KLEIN) begin
            nb_cpm = CP'(r_cols) + CP'(1) - nb_cp;
        end else begin
            nb_cpm = nb_cp;
        end
        if (nb_cpm == '0) begin
            nb_col = CI'(r_cols - 1'b1);
        end else if (nb_cpm == CP'(r_cols) + CP'(1)) begin
            nb_col = '0;
        end else begin
            nb_col = CI'(nb_cpm - 1'b1);
        end
    end

    always_comb begin
        cnt_blue = '0;
        cnt_red  = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                if (!(a == 1 && b == 1)) begin
                    cnt_blue = cnt_blue + 4'(r_win[a][b] == CELL_BLUE);
                    cnt_red  = cnt_red + 4'(r_win[a][b] == CELL_RED);
                end
            end
        end
        new_cell = cell_rule(r_win[1][1], cnt_blue, cnt_red);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept && i_req_type == REQ_READ) begin
                    n_state = ST_RESP;
                end else if (accept && i_req_type == REQ_GEN) begin
                    n_state = ST_GRD;
                end
            end
            ST_RESP:  n_state = ST_IDLE;
            ST_GRD:   if (last_rd) n_state = ST_GWAIT;
            ST_GWAIT: n_state = ST_GEVAL;
            ST_GEVAL: n_state = (last_col && last_row) ? ST_COPY : ST_GRD;
            ST_COPY:  if (last_col && last_row) n_state = ST_COPYW;
            ST_COPYW: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = r_cp_addr;
        cell_wdata = next_rdata;
        cell_raddr = {nb_row, nb_col};
        next_we    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = r_clr;
                cell_wdata = CELL_EMPTY;
            end
            ST_IDLE: begin
                cell_raddr = req_addr;
                if (accept && i_req_type == REQ_WRITE && req_inside) begin
                    cell_we    = 1'b1;
                    cell_waddr = req_addr;
                    cell_wdata = (i_cell_in == CELL_BAD) ? CELL_EMPTY : i_cell_in;
                end
            end
            ST_GEVAL: next_we = 1'b1;
            ST_COPY:  cell_we = r_cp_vld;
            ST_COPYW: cell_we = r_cp_vld;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_rows   <= clamp_rows(7'd64);
            r_cols   <= clamp_cols(7'd64);
            r_topo   <= TOPO_TORUS;
            r_clr    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_ld_vld <= 1'b0;
            r_cp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ld_vld <= 1'b0;
            r_cp_vld <= 1'b0;
            r_done   <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows <= clamp_rows(i_cfg_data);
                    CFG_COLS: r_cols <= clamp_cols(i_cfg_data);
                    CFG_TOPO: r_topo <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_IDLE: begin
                    r_row <= '0;
                    r_col <= '0;
                    r_i   <= '0;
                    r_j   <= '0;
                    if (accept && i_req_type != REQ_READ && i_req_type != REQ_GEN) begin
                        r_done     <= 1'b1;
                        r_cell_out <= CELL_EMPTY;
                        r_is_read  <= 1'b0;
                    end
                end
                ST_RESP: begin
                    r_done     <= 1'b1;
                    r_cell_out <= r_req_in ? cell_rdata : CELL_EMPTY;
                    r_is_read  <= 1'b1;
                end
                ST_GRD: begin
                    r_ld_vld <= 1'b1;
                    r_ld_i   <= r_i;
                    r_ld_j   <= r_j;
                    if (r_i == 2'd2) begin
                        r_i <= '0;
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_GEVAL: begin
                    r_i <= '0;
                    if (last_col) begin
                        r_col <= '0;
                        r_j   <= '0;
                        r_row <= last_row ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                        r_j   <= 2'd2;
                    end
                end
                ST_COPY: begin
                    r_cp_vld  <= 1'b1;
                    r_cp_addr <= {r_row, r_col};
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= last_row ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_COPYW: begin
                    r_done     <= 1'b1;
                    r_cell_out <= CELL_EMPTY;
                    r_is_read  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_req_in <= req_inside;
        end
        if (r_state == ST_GEVAL) begin
            for (int a = 0; a < 3; a++) begin
                r_win[a][0] <= r_win[a][1];
                r_win[a][1] <= r_win[a][2];
            end
        end else if (r_ld_vld) begin
            r_win[r_ld_i][r_ld_j] <= cell_rdata;
        end
    end

    assign o_done     = r_done;
    assign o_cell_out = r_cell_out;
    assign o_is_read  = r_is_read;

    tslg_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    tslg_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr ({r_row, r_col}),
        .i_wdata (new_cell),
        .i_raddr ({r_row, r_col}),
        .o_rdata (next_rdata)
    );

endmodule

// ----- sv/tslg_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslg_chk: port-level checks for the two-species life block
// Watches requests and result strobes on the top-level ports.
// ----------------------------------------------------------------------------
module tslg_chk
    import tslg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_req_type,
    input logic       o_done,
    input logic [1:0] o_cell_out,
    input logic       o_is_read
);

    // busy through the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    // a write word is answered in the next cycle
    a_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_WRITE |=> o_done && !o_is_read)
        else $error("write word not answered");

    // a read word holds busy one cycle and is answered after it
    a_read_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_READ |=> busy ##1 (o_done && o_is_read))
        else $error("read word not answered");

    // non-read results carry an empty cell
    a_nonread_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_is_read |-> o_cell_out == CELL_EMPTY)
        else $error("non-read word carries a cell");

endmodule

bind two_species_life_generation tslg_chk u_tslg_chk (.*);

// ----- tb/two_species_life_generation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_species_life_generation_tb: self-checking bench for the life grid block
// Walks a directed table of writes, reads and generations across size and
// topology settings, then runs random phases, most with bursty request traffic.
// Every result word is checked against a cell-level model of the grid or a typed table result.
// ----------------------------------------------------------------------------
module two_species_life_generation_tb;
    import tslg_pkg::*;

    localparam int GRID_MAX     = 64;
    localparam int END_SLACK    = 32;
    localparam int TIMEOUT_NS   = 40_000_000;
    localparam int PHASES       = 7;
    localparam int PHASE_WORDS  = 17;
    localparam int REPORT_LIMIT = 10;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] cell_val;
        logic       is_read;
    } t_result_word;

    typedef struct {
        bit           is_cfg;
        logic [1:0]   cfg_idx;
        logic [6:0]   cfg_val;
        logic [1:0]   req;
        logic [5:0]   row;
        logic [5:0]   col;
        logic [1:0]   cell_val;
        bit           typed;
        t_result_word typed_res;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_req_type;
    logic [5:0] i_row;
    logic [5:0] i_col;
    logic [1:0] i_cell_in;
    logic       o_done;
    logic [1:0] o_cell_out;
    logic       o_is_read;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    t_stim_row    stim_tab[$];
    t_result_word pending_results[$];
    logic [1:0]   life_grid[GRID_MAX][GRID_MAX];
    logic [1:0]   scratch_grid[GRID_MAX][GRID_MAX];
    logic [6:0]   pred_rows;
    logic [6:0]   pred_cols;
    logic         pred_topo;
    int           mismatches;
    bit           word_typed;
    t_result_word word_typed_res;

    two_species_life_generation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_cell_in  (i_cell_in),
        .o_done     (o_done),
        .o_cell_out (o_cell_out),
        .o_is_read  (o_is_read),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int active_dim(logic [6:0] v);
        if (v < 7'd4) begin
            return 4;
        end
        if (int'(v) > GRID_MAX) begin
            return GRID_MAX;
        end
        return int'(v);
    endfunction

    function automatic int wrap_index(int c, int n);
        if (c < 0) begin
            return n - 1;
        end
        if (c >= n) begin
            return 0;
        end
        return c;
    endfunction

    function automatic logic [1:0] next_cell(logic [1:0] self, int nblue, int nred);
        int total;
        total = nblue + nred;
        if (self == CELL_EMPTY) begin
            if (total == int'(BIRTH_COUNT)) begin
                return (nblue > nred) ? CELL_BLUE : CELL_RED;
            end
            if (total == int'(HIGH_BIRTH_COUNT) && nred > nblue) begin
                return CELL_RED;
            end
            return CELL_EMPTY;
        end
        if (total == int'(STAY_COUNT) || total == int'(BIRTH_COUNT)) begin
            return self;
        end
        return CELL_EMPTY;
    endfunction

    task automatic advance_life();
        int nrows;
        int ncols;
        int nblue;
        int nred;
        int rr;
        int cc;
        int nr;
        int nc;
        bit wrapped;
        logic [1:0] v;
        nrows = active_dim(pred_rows);
        ncols = active_dim(pred_cols);
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < ncols; c++) begin
                nblue = 0;
                nred  = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    rr      = r + dr;
                    wrapped = (rr < 0) || (rr >= nrows);
                    nr      = wrap_index(rr, nrows);
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (!(dr == 0 && dc == 0)) begin
                            cc = c + dc;
                            // klein bottle: column mirrors when the row wraps
                            if (wrapped && pred_topo == TOPO_KLEIN) begin
                                cc = ncols - 1 - cc;
                            end
                            nc = wrap_index(cc, ncols);
                            v  = life_grid[nr][nc];
                            if (v == CELL_BLUE) begin
                                nblue++;
                            end else if (v == CELL_RED) begin
                                nred++;
                            end
                        end
                    end
                end
                scratch_grid[r][c] = next_cell(life_grid[r][c], nblue, nred);
            end
        end
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < ncols; c++) begin
                life_grid[r][c] = scratch_grid[r][c];
            end
        end
    endtask

    task automatic predict_word(input logic [1:0] req, input logic [5:0] row,
                                input logic [5:0] col, input logic [1:0] cell_val,
                                output t_result_word res);
        bit in_area;
        in_area = (int'(row) < active_dim(pred_rows)) && (int'(col) < active_dim(pred_cols));
        res = '0;
        case (req)
            REQ_WRITE: begin
                if (in_area) begin
                    life_grid[row][col] = (cell_val == CELL_BAD) ? CELL_EMPTY : cell_val;
                end
            end
            REQ_GEN: begin
                advance_life();
            end
            REQ_READ: begin
                res.cell_val = in_area ? life_grid[row][col] : CELL_EMPTY;
                res.is_read  = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result_word want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("result word with none pending: cell_out %0d is_read %0d",
                                            o_cell_out, o_is_read));
                end else begin
                    want = pending_results.pop_front();
                    if (o_cell_out !== want.cell_val) begin
                        note_mismatch($sformatf("cell_out expected %0d got %0d",
                                                want.cell_val, o_cell_out));
                    end
                    if (o_is_read !== want.is_read) begin
                        note_mismatch($sformatf("is_read expected %0d got %0d",
                                                want.is_read, o_is_read));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: pred_rows = i_cfg_data;
                    CFG_COLS: pred_cols = i_cfg_data;
                    CFG_TOPO: pred_topo = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (start && !busy) begin
                predict_word(i_req_type, i_row, i_col, i_cell_in, want);
                if (word_typed) begin
                    want = word_typed_res;
                end
                pending_results.push_back(want);
            end
        end
    end

    task automatic send_word(input logic [1:0] req, input logic [5:0] row,
                             input logic [5:0] col, input logic [1:0] cell_val,
                             input bit typed, input t_result_word tres);
        @(negedge i_clk);
        start          <= 1'b1;
        i_req_type     <= req;
        i_row          <= row;
        i_col          <= col;
        i_cell_in      <= cell_val;
        word_typed     = typed;
        word_typed_res = tres;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic hold_off(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic void tab_req(logic [1:0] req, logic [5:0] row, logic [5:0] col,
                                    logic [1:0] cell_val, bit typed, logic [1:0] tcell,
                                    logic tread);
        t_stim_row e;
        e.is_cfg             = 1'b0;
        e.cfg_idx            = CFG_ROWS;
        e.cfg_val            = '0;
        e.req                = req;
        e.row                = row;
        e.col                = col;
        e.cell_val           = cell_val;
        e.typed              = typed;
        e.typed_res.cell_val = tcell;
        e.typed_res.is_read  = tread;
        stim_tab.push_back(e);
    endfunction

    function automatic void tab_cfg(logic [1:0] idx, logic [6:0] val);
        t_stim_row e;
        e.is_cfg    = 1'b1;
        e.cfg_idx   = idx;
        e.cfg_val   = val;
        e.req       = REQ_WRITE;
        e.row       = '0;
        e.col       = '0;
        e.cell_val  = CELL_EMPTY;
        e.typed     = 1'b0;
        e.typed_res = '0;
        stim_tab.push_back(e);
    endfunction

    // mostly near the low or high edge of the area, so wraps see live cells
    function automatic int pick_coord(int n);
        int k;
        int lim;
        k   = $urandom_range(0, 99);
        lim = (n > 12) ? 12 : n;
        if (k < 15) begin
            return $urandom_range(0, 63);
        end
        if (k < 57) begin
            return $urandom_range(0, lim - 1);
        end
        return n - 1 - $urandom_range(0, lim - 1);
    endfunction

    function automatic logic [6:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return 7'd0;
            1:       return 7'd3;
            2:       return 7'd127;
            3:       return 7'd65;
            4:       return 7'd64;
            5:       return 7'd4;
            default: return 7'($urandom_range(5, 12));
        endcase
    endfunction

    initial begin
        #TIMEOUT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int           n_rows;
        int           n_cols;
        int           burst_left;
        int           gens_left;
        int           k;
        logic [6:0]   dim_r;
        logic [6:0]   dim_c;
        logic         topo;
        bit           bursty;
        logic [1:0]   req;
        t_result_word none;

        start          = 1'b0;
        i_req_type     = REQ_WRITE;
        i_row          = '0;
        i_col          = '0;
        i_cell_in      = CELL_EMPTY;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_ROWS;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        mismatches     = 0;
        word_typed     = 1'b0;
        word_typed_res = '0;
        none           = '0;
        pred_rows      = 7'd64;
        pred_cols      = 7'd64;
        pred_topo      = TOPO_TORUS;
        for (int r = 0; r < GRID_MAX; r++) begin
            for (int c = 0; c < GRID_MAX; c++) begin
                life_grid[r][c]    = CELL_EMPTY;
                scratch_grid[r][c] = CELL_EMPTY;
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full grid, torus: corners, bad value, spare code, wrap-around birth
        tab_req(REQ_READ,  6'd0,  6'd0,  CELL_EMPTY, 1, CELL_EMPTY, 1'b1);
        tab_req(REQ_READ,  6'd63, 6'd63, CELL_EMPTY, 1, CELL_EMPTY, 1'b1);
        tab_req(REQ_WRITE, 6'd0,  6'd0,  CELL_BLUE,  1, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd63, 6'd63, CELL_RED,   1, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd0,  6'd63, CELL_BAD,   1, CELL_EMPTY, 1'b0);
        tab_req(REQ_READ,  6'd0,  6'd0,  CELL_EMPTY, 1, CELL_BLUE,  1'b1);
        tab_req(REQ_READ,  6'd63, 6'd63, CELL_EMPTY, 1, CELL_RED,   1'b1);
        tab_req(REQ_READ,  6'd0,  6'd63, CELL_EMPTY, 1, CELL_EMPTY, 1'b1);
        tab_req(REQ_SPARE, 6'd63, 6'd63, CELL_BAD,   1, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd63, 6'd0,  CELL_BLUE,  1, CELL_EMPTY, 1'b0);
        tab_req(REQ_GEN,   6'd0,  6'd0,  CELL_EMPTY, 1, CELL_EMPTY, 1'b0);
        tab_req(REQ_READ,  6'd0,  6'd63, CELL_EMPTY, 0, CELL_EMPTY, 1'b0);
        // sizes out of range, klein bottle, accesses outside the area
        tab_cfg(CFG_ROWS, 7'd0);
        tab_cfg(CFG_COLS, 7'd127);
        tab_cfg(CFG_TOPO, 7'd1);
        tab_cfg(CFG_SPARE, 7'h55);
        tab_req(REQ_WRITE, 6'd5,  6'd5,  CELL_RED,   1, CELL_EMPTY, 1'b0);
        tab_req(REQ_READ,  6'd5,  6'd5,  CELL_EMPTY, 1, CELL_EMPTY, 1'b1);
        tab_req(REQ_GEN,   6'd0,  6'd0,  CELL_EMPTY, 1, CELL_EMPTY, 1'b0);
        tab_req(REQ_READ,  6'd3,  6'd0,  CELL_EMPTY, 0, CELL_EMPTY, 1'b0);
        tab_cfg(CFG_ROWS, 7'd3);
        tab_cfg(CFG_COLS, 7'd4);
        tab_req(REQ_READ,  6'd0,  6'd63, CELL_EMPTY, 1, CELL_EMPTY, 1'b1);
        // six red around an empty cell
        tab_req(REQ_WRITE, 6'd0,  6'd0,  CELL_RED,   0, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd0,  6'd1,  CELL_RED,   0, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd0,  6'd2,  CELL_RED,   0, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd2,  6'd0,  CELL_RED,   0, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd2,  6'd1,  CELL_RED,   0, CELL_EMPTY, 1'b0);
        tab_req(REQ_WRITE, 6'd2,  6'd2,  CELL_RED,   0, CELL_EMPTY, 1'b0);
        tab_req(REQ_GEN,   6'd0,  6'd0,  CELL_EMPTY, 0, CELL_EMPTY, 1'b0);
        tab_req(REQ_READ,  6'd1,  6'd1,  CELL_EMPTY, 0, CELL_EMPTY, 1'b0);

        wait_idle();
        foreach (stim_tab[i]) begin
            if (stim_tab[i].is_cfg) begin
                wait_idle();
                write_reg(stim_tab[i].cfg_idx, stim_tab[i].cfg_val);
            end else begin
                send_word(stim_tab[i].req, stim_tab[i].row, stim_tab[i].col,
                          stim_tab[i].cell_val, stim_tab[i].typed, stim_tab[i].typed_res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            if (p == 0) begin
                dim_r = 7'd64;
                dim_c = 7'd64;
                topo  = TOPO_KLEIN;
            end else begin
                dim_r = pick_dim();
                dim_c = pick_dim();
                topo  = 1'($urandom_range(0, 1));
            end
            write_reg(CFG_ROWS, dim_r);
            write_reg(CFG_COLS, dim_c);
            write_reg(CFG_TOPO, {6'($urandom_range(0, 63)), topo});
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_SPARE, 7'($urandom_range(0, 127)));
            end
            n_rows     = active_dim(dim_r);
            n_cols     = active_dim(dim_c);
            gens_left  = (n_rows > 16 && n_cols > 16) ? 2 : 8;
            bursty     = (p % 3) != 1;
            burst_left = $urandom_range(1, 12);
            for (int w = 0; w < PHASE_WORDS; w++) begin
                k = $urandom_range(0, 99);
                if (k < 45) begin
                    req = REQ_WRITE;
                end else if (k < 78) begin
                    req = REQ_READ;
                end else if (k < 93 && gens_left > 0) begin
                    req = REQ_GEN;
                    gens_left--;
                end else if (k < 93) begin
                    req = REQ_READ;
                end else begin
                    req = REQ_SPARE;
                end
                send_word(req, 6'(pick_coord(n_rows)), 6'(pick_coord(n_cols)),
                          2'($urandom_range(0, 3)), 1'b0, none);
                if (bursty) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        hold_off($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 12);
                    end
                end
                if (p == 2 && w == PHASE_WORDS / 2) begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (END_SLACK) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            note_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
